// ===== src/binary_frame_receiver_unit_macros.svh =====
// assertion macros for the binary frame receiver unit
`ifndef BINARY_FRAME_RECEIVER_UNIT_MACROS_SVH
`define BINARY_FRAME_RECEIVER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, clocked on clk, off while arst_n is low
`define BFR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bfr assertion failed");

// next-cycle implication, clocked on clk, off while arst_n is low
`define BFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bfr assertion failed");

`else

`define BFR_ASSERT_SAME(label, ante, cons)
`define BFR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/bfr_pkg.sv =====
// shared types and constants of the binary frame receiver
package bfr_pkg;

	localparam int unsigned BUFFER_BYTES_DEF = 256;
	localparam int unsigned HDR_BYTES        = 4;
	localparam int unsigned BORDER_BYTES     = 8;
	localparam int unsigned CK_W             = 15;
	localparam int unsigned CMP_W            = 10;

	localparam logic [7:0] SYNC0_BYTE  = 8'hA0;
	localparam logic [7:0] SYNC1_BYTE  = 8'hA2;
	localparam logic [7:0] LEN_HI_BYTE = 8'h00;
	localparam logic [7:0] STOP_BYTE   = 8'hB3;

	localparam logic ACT_RECV = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_FRAME_OK,
		EV_CKSUM_ERR,
		EV_SIZE_ERR
	} bfr_event_t;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
		logic [7:0] read_index;
	} bfr_item_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [7:0]  payload_length;
		logic [7:0]  read_data;
		logic [31:0] bytes_received;
		logic [31:0] bytes_processed;
		logic [31:0] packets_processed;
		logic [31:0] size_errors;
		logic [31:0] checksum_errors;
	} bfr_result_t;

	// classified request as queued between front and back
	typedef struct packed {
		logic       is_read;
		logic [7:0] rx_byte;
		logic       rd_ok;
		logic [7:0] rd_addr;
	} bfr_req_t;

endpackage

// ===== src/bfr_front.sv =====
// front end: accepts requests, classifies them and queues them for the back end
module bfr_front #(
	parameter int unsigned BUFFER_BYTES = bfr_pkg::BUFFER_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  bfr_pkg::bfr_item_t item,
	output logic               q_valid,
	input  logic               q_pop,
	output bfr_pkg::bfr_req_t  q_head
);
	import bfr_pkg::*;

	bfr_req_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	bfr_req_t   req;
	logic [8:0] rd_sum;
	logic       push;

	always_comb begin
		rd_sum      = {1'b0, item.read_index} + 9'(HDR_BYTES);
		req.is_read = (item.action == ACT_READ);
		req.rx_byte = item.rx_byte;
		req.rd_ok   = (rd_sum < 9'(BUFFER_BYTES));
		req.rd_addr = rd_sum[7:0];
	end

	assign item_stall = (count_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign q_valid    = (count_q != 2'd0);
	assign q_head     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/bfr_back.sv =====
// back end: frame tracking, frame store, statistics and result register
module bfr_back #(
	parameter int unsigned BUFFER_BYTES = bfr_pkg::BUFFER_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  bfr_pkg::bfr_req_t    q_head,
	output logic                 result_valid,
	input  logic                 result_stall,
	output bfr_pkg::bfr_result_t result
);
	import bfr_pkg::*;

	localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);
	localparam int unsigned POS_W  = $clog2(BUFFER_BYTES + 1);

	logic [7:0]       frame_store_q [BUFFER_BYTES];
	logic [7:0]       rdata_q;
	logic [POS_W-1:0] pos_q;
	logic [CK_W-1:0]  sum_q;
	logic [7:0]       len_q;
	logic [7:0]       ckhi_q;
	logic [7:0]       cklo_q;
	logic [31:0]      received_q;
	logic [31:0]      processed_q;
	logic [31:0]      frames_q;
	logic [31:0]      size_err_q;
	logic [31:0]      cksum_err_q;

	logic             valid_s1;
	bfr_event_t       event_s1;
	logic [7:0]       len_s1;
	logic             rdsel_s1;

	logic             advance;
	logic             do_recv;
	logic             do_read;
	logic [7:0]       b;
	logic [POS_W-1:0] at;
	logic [CMP_W-1:0] at_w;
	logic [CMP_W-1:0] fp_w;
	logic [CMP_W-1:0] len_w;
	logic [7:0]       len_eff;
	logic             in_payload;
	logic             ck_match;
	logic [POS_W-1:0] pos_n;
	logic [CK_W-1:0]  sum_n;
	bfr_event_t       ev;

	assign advance = q_valid && (!valid_s1 || !result_stall);
	assign q_pop   = advance;
	assign do_recv = advance && !q_head.is_read;
	assign do_read = advance && q_head.is_read && q_head.rd_ok;

	always_comb begin
		b          = q_head.rx_byte;
		at         = (pos_q >= POS_W'(BUFFER_BYTES)) ? '0 : pos_q;
		at_w       = CMP_W'(at);
		fp_w       = at_w + CMP_W'(1);
		len_eff    = (at_w == CMP_W'(3)) ? b : len_q;
		len_w      = CMP_W'(len_eff);
		in_payload = (at_w >= CMP_W'(HDR_BYTES)) && (at_w < len_w + CMP_W'(HDR_BYTES));
		ck_match   = (ckhi_q == {1'b0, sum_q[CK_W-1:8]}) && (cklo_q == sum_q[7:0]);
		pos_n      = POS_W'(fp_w);
		sum_n      = (at_w == '0) ? '0 : sum_q;
		ev         = EV_NONE;
		if (in_payload) begin
			sum_n = sum_q + CK_W'(b);
		end
		if (at_w == CMP_W'(0)) begin
			if (b != SYNC0_BYTE) begin
				pos_n = '0;
			end
		end else if (at_w == CMP_W'(1)) begin
			if (b != SYNC1_BYTE) begin
				pos_n = '0;
			end
		end else if (at_w == CMP_W'(2)) begin
			if (b != LEN_HI_BYTE) begin
				pos_n = '0;
				ev    = EV_SIZE_ERR;
			end
		end else if (len_w + CMP_W'(BORDER_BYTES) < fp_w) begin
			pos_n = '0;
			ev    = EV_SIZE_ERR;
		end else if (len_w + CMP_W'(BORDER_BYTES) == fp_w && b == STOP_BYTE) begin
			pos_n = '0;
			ev    = ck_match ? EV_FRAME_OK : EV_CKSUM_ERR;
		end
	end

	always_ff @(posedge clk) begin
		if (do_recv) begin
			frame_store_q[at[ADDR_W-1:0]] <= b;
		end
		if (do_read) begin
			rdata_q <= frame_store_q[q_head.rd_addr[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_s1 <= q_head.is_read ? EV_NONE : ev;
			len_s1   <= (!q_head.is_read && ev == EV_FRAME_OK) ? len_eff : 8'h00;
			rdsel_s1 <= q_head.is_read && q_head.rd_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pos_q       <= '0;
			sum_q       <= '0;
			len_q       <= 8'h00;
			ckhi_q      <= 8'h00;
			cklo_q      <= 8'h00;
			received_q  <= 32'd0;
			processed_q <= 32'd0;
			frames_q    <= 32'd0;
			size_err_q  <= 32'd0;
			cksum_err_q <= 32'd0;
		end else begin
			if (advance) begin
				valid_s1 <= 1'b1;
			end else if (!result_stall) begin
				valid_s1 <= 1'b0;
			end
			if (do_recv) begin
				pos_q      <= pos_n;
				sum_q      <= sum_n;
				received_q <= received_q + 32'd1;
				if (at_w == CMP_W'(3)) begin
					len_q <= b;
				end
				if (at_w == len_w + CMP_W'(HDR_BYTES)) begin
					ckhi_q <= b;
				end
				if (at_w == len_w + CMP_W'(HDR_BYTES + 1)) begin
					cklo_q <= b;
				end
				case (ev)
					EV_FRAME_OK: begin
						frames_q    <= frames_q + 32'd1;
						processed_q <= processed_q + 32'(fp_w);
					end
					EV_CKSUM_ERR: cksum_err_q <= cksum_err_q + 32'd1;
					EV_SIZE_ERR:  size_err_q  <= size_err_q + 32'd1;
					default:      ;
				endcase
			end
		end
	end

	// counters only move when the next request enters the result register
	always_comb begin
		result.event_res         = event_s1;
		result.payload_length    = len_s1;
		result.read_data         = rdsel_s1 ? rdata_q : 8'h00;
		result.bytes_received    = received_q;
		result.bytes_processed   = processed_q;
		result.packets_processed = frames_q;
		result.size_errors       = size_err_q;
		result.checksum_errors   = cksum_err_q;
	end

	assign result_valid = valid_s1;

endmodule

// ===== src/binary_frame_receiver_unit.sv =====
// binary frame receiver unit, top level
// Takes one request per clock while item_stall is low (a received line byte or a
// read of a stored payload byte) and returns one result per request, once it has
// passed the queue and then the result register. A two-entry queue sits between the
// classifying front end and the frame engine and holds new requests while the
// previous result waits; the frame engine handles one byte per cycle, unless the
// result side stalls, with a running checksum, and the single-port frame store
// serves either the byte write or the payload read of that cycle. Reads of store
// entries never written return undefined data.
`include "binary_frame_receiver_unit_macros.svh"

module binary_frame_receiver_unit #(
	parameter int unsigned BUFFER_BYTES = bfr_pkg::BUFFER_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  bfr_pkg::bfr_item_t   item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output bfr_pkg::bfr_result_t result
);
	import bfr_pkg::*;

	logic     q_valid;
	logic     q_pop;
	bfr_req_t q_head;

	bfr_front #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_head     (q_head)
	);

	bfr_back #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_head       (q_head),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	`BFR_ASSERT_SAME(a_stall_needs_queued, item_stall, q_valid)
	`BFR_ASSERT_NEXT(a_empty_result_fills, q_valid && !result_valid, result_valid)
	`BFR_ASSERT_SAME(a_len_only_on_ok, result_valid && result.event_res != EV_FRAME_OK, result.payload_length == 8'h00)
	`BFR_ASSERT_SAME(a_read_data_only_on_read, result_valid && result.event_res != EV_NONE, result.read_data == 8'h00)

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for the binary frame receiver unit
module testbench;
	import bfr_pkg::*;

	localparam int unsigned STORE_BYTES = BUFFER_BYTES_DEF;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_ITEMS = 950;
	localparam int unsigned CALM_ITEMS = 200;

	typedef enum int {
		KIND_GOOD,
		KIND_BAD_CKSUM,
		KIND_BAD_STOP
	} frame_kind_t;

	class frame_scoreboard;
		bfr_result_t result_q[$];
		int unsigned mismatches;
		logic [7:0] store_copy [STORE_BYTES];
		bit written [STORE_BYTES];
		int unsigned position;
		logic [15:0] cksum_acc;
		logic [31:0] rx_count;
		logic [31:0] ok_byte_count;
		logic [31:0] ok_frame_count;
		logic [31:0] size_err_count;
		logic [31:0] cksum_err_count;

		function new();
			mismatches = 0;
			position = 0;
			cksum_acc = '0;
			rx_count = '0;
			ok_byte_count = '0;
			ok_frame_count = '0;
			size_err_count = '0;
			cksum_err_count = '0;
			foreach (written[i]) begin
				written[i] = 1'b0;
				store_copy[i] = '0;
			end
		endfunction

		function int unsigned pending();
			return result_q.size();
		endfunction

		// advance the frame state by one accepted request
		function void note(bfr_item_t it);
			bfr_result_t r;
			bfr_event_t ev;
			int unsigned at;
			int unsigned len;
			logic [7:0] b;
			logic [15:0] ck;
			r = '0;
			ev = EV_NONE;
			if (it.action == ACT_READ) begin
				at = int'(it.read_index) + HDR_BYTES;
				if (at < STORE_BYTES)
					r.read_data = store_copy[at];
			end else begin
				b = it.rx_byte;
				if (position >= STORE_BYTES)
					position = 0;
				at = position;
				store_copy[at] = b;
				written[at] = 1'b1;
				position = at + 1;
				rx_count = rx_count + 1;
				if (at == 0)
					cksum_acc = '0;
				len = (at >= 3) ? int'(store_copy[3]) : 0;
				if (at >= HDR_BYTES && at < len + HDR_BYTES)
					cksum_acc = cksum_acc + b;
				if (position == 1) begin
					if (b != SYNC0_BYTE)
						position = 0;
				end else if (position == 2) begin
					if (b != SYNC1_BYTE)
						position = 0;
				end else if (position == 3) begin
					if (b != LEN_HI_BYTE) begin
						size_err_count = size_err_count + 1;
						position = 0;
						ev = EV_SIZE_ERR;
					end
				end else if (len + BORDER_BYTES < position) begin
					size_err_count = size_err_count + 1;
					position = 0;
					ev = EV_SIZE_ERR;
				end
				if (position >= BORDER_BYTES && len + BORDER_BYTES == position
						&& b == STOP_BYTE) begin
					ck = cksum_acc & 16'h7FFF;
					if (store_copy[position - 4] == ck[15:8]
							&& store_copy[position - 3] == ck[7:0]) begin
						ok_frame_count = ok_frame_count + 1;
						ok_byte_count = ok_byte_count + position;
						r.payload_length = len[7:0];
						ev = EV_FRAME_OK;
					end else begin
						cksum_err_count = cksum_err_count + 1;
						ev = EV_CKSUM_ERR;
					end
					position = 0;
				end
			end
			r.event_res = ev;
			r.bytes_received = rx_count;
			r.bytes_processed = ok_byte_count;
			r.packets_processed = ok_frame_count;
			r.size_errors = size_err_count;
			r.checksum_errors = cksum_err_count;
			result_q.push_back(r);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %0h expected %0h", what, got, want);
			mismatches++;
		endtask

		task compare(string what, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report(what, got, want);
		endtask

		task check(bfr_result_t got);
			bfr_result_t want;
			if (result_q.size() == 0) begin
				report("result with no request waiting", got.bytes_received, '0);
				return;
			end
			want = result_q.pop_front();
			compare("event_res", got.event_res, want.event_res);
			compare("payload_length", got.payload_length, want.payload_length);
			compare("read_data", got.read_data, want.read_data);
			compare("bytes_received", got.bytes_received, want.bytes_received);
			compare("bytes_processed", got.bytes_processed, want.bytes_processed);
			compare("packets_processed", got.packets_processed, want.packets_processed);
			compare("size_errors", got.size_errors, want.size_errors);
			compare("checksum_errors", got.checksum_errors, want.checksum_errors);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	bfr_item_t item;
	logic result_valid;
	logic result_stall;
	bfr_result_t result;

	frame_scoreboard sb = new();
	bit idle_on = 1'b1;
	bit mix_reads = 1'b0;
	int unsigned items_sent = 0;
	int unsigned stall_left = 0;
	int unsigned cycles = 0;

	binary_frame_receiver_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	// result side: check and stall in bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall)
				sb.check(result);
			if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 4);
			result_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	task automatic push(input bfr_item_t it);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note(it);
		items_sent++;
	endtask

	task automatic send_read_at(input logic [7:0] idx);
		bfr_item_t it;
		it.action = ACT_READ;
		it.rx_byte = 8'($urandom_range(0, 255));
		it.read_index = idx;
		push(it);
	endtask

	// pick an index whose store entry holds data, or one past the store
	task automatic send_read();
		int unsigned idx;
		idx = $urandom_range(0, 255);
		if (idx + HDR_BYTES < STORE_BYTES && !sb.written[idx + HDR_BYTES])
			idx = 252 + $urandom_range(0, 3);
		send_read_at(8'(idx));
	endtask

	task automatic send_byte(input logic [7:0] b);
		bfr_item_t it;
		if (mix_reads && $urandom_range(0, 15) == 0)
			send_read();
		it.action = ACT_RECV;
		it.rx_byte = b;
		it.read_index = 8'($urandom_range(0, 255));
		push(it);
	endtask

	task automatic send_frame(input frame_kind_t kind, input int unsigned len);
		logic [15:0] acc;
		logic [7:0] b;
		acc = '0;
		send_byte(SYNC0_BYTE);
		send_byte(SYNC1_BYTE);
		send_byte(LEN_HI_BYTE);
		send_byte(8'(len));
		repeat (len) begin
			b = 8'($urandom_range(0, 255));
			acc = acc + b;
			send_byte(b);
		end
		acc = acc & 16'h7FFF;
		if (kind == KIND_BAD_CKSUM)
			acc = acc ^ (16'h1 << $urandom_range(0, 14));
		send_byte(acc[15:8]);
		send_byte(acc[7:0]);
		send_byte(8'($urandom_range(0, 255)));
		if (kind == KIND_BAD_STOP) begin
			b = 8'($urandom_range(0, 255));
			if (b == STOP_BYTE)
				b = 8'h00;
			send_byte(b);
			send_byte(8'($urandom_range(0, 255)));
		end else begin
			send_byte(STOP_BYTE);
		end
	endtask

	initial begin
		logic [7:0] seq [$];
		int unsigned pick;
		int unsigned stop_at;
		int unsigned calm_at;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty frame, then reads at both index extremes
		seq = '{SYNC0_BYTE, SYNC1_BYTE, LEN_HI_BYTE, 8'h00, 8'h00, 8'h00, 8'hFF, STOP_BYTE};
		foreach (seq[i])
			send_byte(seq[i]);
		send_read_at(8'h00);
		send_read_at(8'hFF);
		// length high nonzero, broken sync, wrong last byte then overrun
		seq = '{SYNC0_BYTE, SYNC1_BYTE, 8'h01, SYNC0_BYTE, 8'h00,
			SYNC0_BYTE, SYNC1_BYTE, LEN_HI_BYTE, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00};
		foreach (seq[i])
			send_byte(seq[i]);

		mix_reads = 1'b1;
		// store wrap, then the longest frame that fits
		send_frame(KIND_GOOD, 255 - $urandom_range(0, 6));
		send_frame(KIND_GOOD, STORE_BYTES - BORDER_BYTES);
		stop_at = items_sent + RANDOM_ITEMS;
		calm_at = stop_at - CALM_ITEMS;
		while (items_sent < stop_at) begin
			if (items_sent >= calm_at)
				idle_on = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 50)
				send_frame(KIND_GOOD, $urandom_range(0, 12));
			else if (pick < 60)
				send_frame(KIND_BAD_CKSUM, $urandom_range(0, 12));
			else if (pick < 66)
				send_frame(KIND_BAD_STOP, $urandom_range(0, 12));
			else if (pick < 71) begin
				send_byte(SYNC0_BYTE);
				send_byte(SYNC1_BYTE);
				send_byte(8'($urandom_range(1, 255)));
			end else if (pick < 79) begin
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 81) begin
				send_byte(SYNC0_BYTE);
				send_byte(8'($urandom_range(0, 8'hA1)));
			end else if (pick < 98) begin
				repeat ($urandom_range(1, 3))
					send_read();
			end else begin
				send_frame(frame_kind_t'($urandom_range(0, 2)), $urandom_range(200, 255));
			end
		end
		item_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+src
src/bfr_pkg.sv
src/bfr_front.sv
src/bfr_back.sv
src/binary_frame_receiver_unit.sv
bench/testbench.sv
